// ===== rtl/rgb_led_pulse_width_encoder_assert.svh =====
`ifndef RGB_LED_PULSE_WIDTH_ENCODER_ASSERT_SVH
`define RGB_LED_PULSE_WIDTH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RLPWE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb led encoder check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RLPWE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb led encoder check failed");

`endif

// ===== rtl/rlpwe_pkg.sv =====
package rlpwe_pkg;

  localparam int CHANNELS         = 3;
  localparam int BITS_PER_CHANNEL = 8;
  localparam int DATA_WORDS       = CHANNELS * BITS_PER_CHANNEL;
  localparam int GAP_MAX          = 40;
  localparam int MAX_WORDS        = DATA_WORDS + GAP_MAX;

  localparam int WORD_W     = 16;
  localparam int SEL_W      = 2;
  localparam int GAP_W      = 6;
  localparam int COLOR_W    = 8;
  localparam int INDEX_W    = $clog2(MAX_WORDS);
  localparam int BIT_W      = $clog2(BITS_PER_CHANNEL);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [SEL_W-1:0]      sel_t;
  typedef logic [GAP_W-1:0]      gap_t;
  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [INDEX_W-1:0]    index_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_addr_t REG_ONE_COMPARE    = 3'd0;
  localparam cfg_addr_t REG_ZERO_COMPARE   = 3'd1;
  localparam cfg_addr_t REG_FIRST_CHANNEL  = 3'd2;
  localparam cfg_addr_t REG_SECOND_CHANNEL = 3'd3;
  localparam cfg_addr_t REG_THIRD_CHANNEL  = 3'd4;
  localparam cfg_addr_t REG_GAP_WORDS      = 3'd5;

  localparam word_t ONE_COMPARE_RST    = 16'd14;
  localparam word_t ZERO_COMPARE_RST   = 16'd7;
  localparam sel_t  FIRST_CHANNEL_RST  = 2'd0;
  localparam sel_t  SECOND_CHANNEL_RST = 2'd2;
  localparam sel_t  THIRD_CHANNEL_RST  = 2'd1;
  localparam gap_t  GAP_WORDS_RST      = 6'd2;

  typedef struct packed {
    word_t                     one_compare;
    word_t                     zero_compare;
    sel_t  [CHANNELS-1:0]      order;
    gap_t                      gap_words;
  } cfg_t;

endpackage

// ===== rtl/rlpwe_cfg_regs.sv =====
module rlpwe_cfg_regs
  import rlpwe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  cfg_addr_t wr_index,
  input  cfg_data_t wr_data,
  output cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_compare  <= ONE_COMPARE_RST;
      cfg.zero_compare <= ZERO_COMPARE_RST;
      cfg.order[0]     <= FIRST_CHANNEL_RST;
      cfg.order[1]     <= SECOND_CHANNEL_RST;
      cfg.order[2]     <= THIRD_CHANNEL_RST;
      cfg.gap_words    <= GAP_WORDS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ONE_COMPARE:    cfg.one_compare  <= wr_data[WORD_W-1:0];
        REG_ZERO_COMPARE:   cfg.zero_compare <= wr_data[WORD_W-1:0];
        REG_FIRST_CHANNEL:  cfg.order[0]     <= wr_data[SEL_W-1:0];
        REG_SECOND_CHANNEL: cfg.order[1]     <= wr_data[SEL_W-1:0];
        REG_THIRD_CHANNEL:  cfg.order[2]     <= wr_data[SEL_W-1:0];
        REG_GAP_WORDS:      cfg.gap_words    <= wr_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/rlpwe_word_gen.sv =====
module rlpwe_word_gen
  import rlpwe_pkg::*;
(
  input  cfg_t                  cfg,
  input  color_t [CHANNELS-1:0] color,
  input  logic                  last_pixel,
  input  index_t                idx,
  output word_t                 word,
  output logic                  final_word
);

  logic [INDEX_W-BIT_W-1:0] slot;
  logic [BIT_W-1:0]         bpos;
  sel_t                     sel;
  color_t                   value;
  gap_t                     gap;
  index_t                   last_idx;

  assign slot = idx[INDEX_W-1:BIT_W];
  assign bpos = ~idx[BIT_W-1:0];

  always_comb begin
    sel = '0;
    if (int'(slot) < CHANNELS) begin
      sel = cfg.order[slot[SEL_W-1:0]];
    end
    // A selector that names no channel sends a channel of all zero bits.
    value = '0;
    if (int'(sel) < CHANNELS) begin
      value = color[sel];
    end
    word = '0;
    if (int'(idx) < DATA_WORDS) begin
      word = value[bpos] ? cfg.one_compare : cfg.zero_compare;
    end
    gap = '0;
    if (last_pixel) begin
      gap = (int'(cfg.gap_words) > GAP_MAX) ? gap_t'(GAP_MAX) : cfg.gap_words;
    end
    last_idx   = index_t'(DATA_WORDS - 1) + index_t'(gap);
    final_word = (idx == last_idx);
  end

endmodule

// ===== rtl/rgb_led_pulse_width_encoder.sv =====
// Pulse-width encoder for a chain of addressable RGB LEDs. Each input beat is one pixel
// (three 8-bit colors, tlast marks the last pixel of the chain); it becomes 24 output
// beats, one compare word per data bit, channels in the configured order and MSB first,
// followed after the last pixel by the configured number of zero words (capped at 40).
// The output beat that ends each pixel carries tlast. One output word leaves the result
// register per cycle unless m_tready stalls it, 24 words per pixel plus the gap after the
// last; the next pixel is taken in the cycle its predecessor's final word is produced.
// Configuration writes are always ready and should only be issued while the block is idle.
module rgb_led_pulse_width_encoder
  import rlpwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // color_0 [7:0], color_1 [15:8], color_2 [23:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // compare_word [15:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_addr_t   cfg_index,
  input  cfg_data_t   cfg_data
);

  cfg_t                  cfg;
  color_t [CHANNELS-1:0] color;
  logic                  last_pixel;
  logic                  busy;
  index_t                idx;
  word_t                 word;
  logic                  final_word;
  logic                  take;
  logic                  adv;
  logic                  accept;

  assign cfg_ready = 1'b1;

  rlpwe_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rlpwe_word_gen u_gen (
    .cfg        (cfg),
    .color      (color),
    .last_pixel (last_pixel),
    .idx        (idx),
    .word       (word),
    .final_word (final_word)
  );

  assign take     = !m_tvalid || m_tready;
  assign adv      = busy && take;
  assign s_tready = !busy || (adv && final_word);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        m_tvalid <= busy;
      end
      if (accept) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        idx <= idx + index_t'(1);
        if (final_word) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= word;
      m_tlast <= final_word;
    end
    if (accept) begin
      color[0]   <= s_tdata[7:0];
      color[1]   <= s_tdata[15:8];
      color[2]   <= s_tdata[23:16];
      last_pixel <= s_tlast;
    end
  end

endmodule

// ===== rtl/rlpwe_checker.sv =====
`include "rgb_led_pulse_width_encoder_assert.svh"

module rlpwe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `RLPWE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `RLPWE_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable({m_tdata, m_tlast}))
  `RLPWE_ASSERT_IMPL(a_pixel_emits, clk, rst, s_tvalid && s_tready, ##2 m_tvalid)
  `RLPWE_ASSERT_IMPL(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind rgb_led_pulse_width_encoder rlpwe_checker u_rlpwe_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import rlpwe_pkg::*;
();

  localparam cfg_addr_t REG_SPARE_LO = 3'd6;
  localparam cfg_addr_t REG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    word_t word;
    logic  run_end;
  } led_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // color_0 [7:0], color_1 [15:8], color_2 [23:16]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // compare_word [15:0]
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_addr_t   cfg_index = '0;
  cfg_data_t   cfg_data = '0;

  word_t     one_word = ONE_COMPARE_RST;
  word_t     zero_word = ZERO_COMPARE_RST;
  sel_t      channel_order [CHANNELS] = '{FIRST_CHANNEL_RST, SECOND_CHANNEL_RST,
                                          THIRD_CHANNEL_RST};
  gap_t      gap_setting = GAP_WORDS_RST;
  led_word_t expected_words [$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;
  int        hold_request = 0;

  rgb_led_pulse_width_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void encode_pixel(color_t c0, color_t c1, color_t c2, logic last);
    color_t    colors [CHANNELS];
    color_t    value;
    int        gap_len;
    led_word_t item;
    colors = '{c0, c1, c2};
    for (int c = 0; c < CHANNELS; c++) begin
      value = (channel_order[c] < CHANNELS) ? colors[channel_order[c]] : '0;
      for (int b = BITS_PER_CHANNEL - 1; b >= 0; b--) begin
        item.word = value[b] ? one_word : zero_word;
        item.run_end = 1'b0;
        expected_words.push_back(item);
      end
    end
    if (last) begin
      gap_len = (gap_setting > GAP_MAX) ? GAP_MAX : int'(gap_setting);
      for (int g = 0; g < gap_len; g++) begin
        item.word = '0;
        item.run_end = 1'b0;
        expected_words.push_back(item);
      end
    end
    expected_words[expected_words.size() - 1].run_end = 1'b1;
  endfunction

  task automatic send_pixel(color_t c0, color_t c1, color_t c2, logic last);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c2, c1, c0};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    encode_pixel(c0, c1, c2, last);
  endtask

  task automatic send_random_pixel(logic last);
    send_pixel(color_t'($urandom), color_t'($urandom), color_t'($urandom), last);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (expected_words.size() == 0);
  endtask

  // The valid stays high across back-to-back writes; only the closing beat lowers it.
  task automatic write_register(cfg_addr_t index, cfg_data_t value, bit closing);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (closing) cfg_valid <= 1'b0;
    case (index)
      REG_ONE_COMPARE:    one_word = value;
      REG_ZERO_COMPARE:   zero_word = value;
      REG_FIRST_CHANNEL:  channel_order[0] = value[SEL_W-1:0];
      REG_SECOND_CHANNEL: channel_order[1] = value[SEL_W-1:0];
      REG_THIRD_CHANNEL:  channel_order[2] = value[SEL_W-1:0];
      REG_GAP_WORDS:      gap_setting = value[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
    send_pixel(8'h80, 8'h01, 8'hF0, 1'b1);
    send_pixel(8'h55, 8'hAA, 8'h3C, 1'b0);
    send_pixel(8'h01, 8'h80, 8'hC3, 1'b1);
    stop_sending();
  endtask

  task automatic test_register_extremes();
    wait_drained();
    write_register(REG_ONE_COMPARE, 16'hFFFF, 1'b0);
    write_register(REG_ZERO_COMPARE, 16'h0000, 1'b0);
    write_register(REG_GAP_WORDS, 16'h0000, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'hA5, 1'b1);
    send_pixel(8'h5A, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    stop_sending();

    // Unused selector reads as zero, a repeated channel goes out twice, gap saturates.
    wait_drained();
    write_register(REG_FIRST_CHANNEL, 16'h0003, 1'b0);
    write_register(REG_SECOND_CHANNEL, 16'h0001, 1'b0);
    write_register(REG_THIRD_CHANNEL, 16'h0001, 1'b0);
    write_register(REG_ONE_COMPARE, 16'h0000, 1'b0);
    write_register(REG_ZERO_COMPARE, 16'hFFFF, 1'b0);
    write_register(REG_GAP_WORDS, 16'hFFFF, 1'b1);
    send_pixel(8'hFF, 8'hC3, 8'hFF, 1'b1);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    stop_sending();

    // High data bits above each field are dropped; spare indexes change nothing.
    wait_drained();
    write_register(REG_FIRST_CHANNEL, 16'hFFFE, 1'b0);
    write_register(REG_SECOND_CHANNEL, 16'hFFFD, 1'b0);
    write_register(REG_THIRD_CHANNEL, 16'hFFFC, 1'b0);
    write_register(REG_GAP_WORDS, 16'h0028, 1'b0);
    write_register(REG_ONE_COMPARE, 16'h8001, 1'b0);
    write_register(REG_ZERO_COMPARE, 16'h7FFE, 1'b0);
    write_register(REG_SPARE_LO, 16'hFFFF, 1'b0);
    write_register(REG_SPARE_HI, 16'hFFFF, 1'b1);
    send_pixel(8'h81, 8'h42, 8'h24, 1'b1);
    send_pixel(8'h7E, 8'hBD, 8'hDB, 1'b0);
    send_pixel(8'hE7, 8'h18, 8'h99, 1'b1);
    stop_sending();

    wait_drained();
    write_register(REG_GAP_WORDS, 16'hFFC1, 1'b0);
    write_register(REG_FIRST_CHANNEL, 16'h0000, 1'b0);
    write_register(REG_SECOND_CHANNEL, 16'h0000, 1'b0);
    write_register(REG_THIRD_CHANNEL, 16'h0003, 1'b1);
    send_pixel(8'hC9, 8'h00, 8'hFF, 1'b1);
    send_pixel(8'h36, 8'hFF, 8'h00, 1'b1);
    stop_sending();
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    write_register(REG_FIRST_CHANNEL, 16'h0002, 1'b0);
    write_register(REG_SECOND_CHANNEL, 16'h0000, 1'b0);
    write_register(REG_THIRD_CHANNEL, 16'h0001, 1'b0);
    write_register(REG_GAP_WORDS, 16'h0004, 1'b1);
    idle_on = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 12; i++) send_random_pixel(i % 4 == 3);
    stop_sending();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int        frame_left;
    cfg_data_t value;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      idle_on = (phase % 3 != 2);
      case ($urandom_range(0, 3))
        0:       value = 16'h0000;
        1:       value = 16'hFFFF;
        default: value = cfg_data_t'($urandom);
      endcase
      write_register(REG_ONE_COMPARE, value, 1'b0);
      write_register(REG_ZERO_COMPARE, cfg_data_t'($urandom), 1'b0);
      write_register(REG_FIRST_CHANNEL, cfg_data_t'($urandom), 1'b0);
      write_register(REG_SECOND_CHANNEL, cfg_data_t'($urandom), 1'b0);
      write_register(REG_THIRD_CHANNEL, cfg_data_t'($urandom), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                       cfg_data_t'($urandom), 1'b0);
      end
      if ($urandom_range(0, 4) == 0) value = cfg_data_t'($urandom);
      else value = {cfg_data_t'($urandom) & 16'hFFC0} | 16'($urandom_range(0, 8));
      write_register(REG_GAP_WORDS, value, 1'b1);
      frame_left = $urandom_range(1, 6);
      for (int i = 0; i < 60; i++) begin
        frame_left--;
        if (frame_left == 0 || $urandom_range(0, 9) == 0) begin
          send_random_pixel(1'b1);
          frame_left = $urandom_range(1, 6);
        end else begin
          send_random_pixel(1'b0);
        end
      end
      stop_sending();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : output_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    led_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output beat: compare_word %0d run_end %0b", m_tdata, m_tlast);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_tdata !== want.word) begin
          $error("compare_word: expected %0d, actual %0d", want.word, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.run_end) begin
          $error("run_end: expected %0b, actual %0b", want.run_end, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $error("no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
